[rtl/irsc_pkg.sv]
// Shared types and constants for the image row scramble cipher.
`timescale 1ns / 1ps

package irsc_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;
  localparam int ROW_STEP  = 7;
  localparam int KEY_MAX   = 255;

  localparam logic [BYTE_W-1:0] EVEN_KEY_INIT = 8'hFF;

  localparam logic [OP_W-1:0] OP_NAME = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

  typedef enum logic [1:0] {
    PH_NAME,
    PH_LOAD,
    PH_FULL,
    PH_READ
  } phase_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RESTART,
    S_RESTART_W,
    S_CHECK,
    S_REDUCE,
    S_REDUCE_W,
    S_MUL,
    S_ACCESS,
    S_OUT,
    S_ADV,
    S_STEP,
    S_STEP_W
  } state_t;

endpackage

[rtl/image_row_scramble_cipher.sv]
// Top level of the image row scramble cipher: sequencer, keys and counters.
//
// Items enter on the in channel (operation, byte_in, first_of_name) with
// valid/ready; results leave on the out channel (byte_out, last_of_image).
// Name bytes build the keys, load bytes fill the frame store, and each read
// item yields exactly one result byte; other items yield none.
// Load and read items pass through the shared remainder unit, which reduces
// the permuted row modulo the row count; a value already below the row
// count is its own remainder. A row wrap and a restart of the counters add
// one more reduction each. A new item is taken only once the last is done.
// After reset, and after every name item marked first_of_name, the block
// clears all MAX_ROWS * MAX_ROW_BYTES bytes of the frame store, one byte a
// cycle, with in_ready low. Configuration writes are taken at any time.
// The result sits in an output register; the block keeps taking items while
// it waits, and a read item stalls only when it needs that register while
// the receiver still holds out_ready low.
`timescale 1ns / 1ps

module image_row_scramble_cipher
  import irsc_pkg::*;
#(
  parameter int MAX_ROWS      = 256,
  parameter int MAX_ROW_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [BYTE_W-1:0]    byte_in,
  input  logic                 first_of_name,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    byte_out,
  output logic                 last_of_image
);

  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int WW    = $clog2(MAX_ROW_BYTES + 1);
  localparam int PW    = HW + WW;
  localparam int DEPTH = MAX_ROWS * MAX_ROW_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW_R  = $clog2(MAX_ROWS + ROW_STEP + 1);
  localparam int DW_K  = $clog2(KEY_MAX + ROW_STEP + 1);
  localparam int DW    = (DW_R > DW_K) ? DW_R : DW_K;

  state_t state, state_next;
  phase_t phase;

  logic [8:0]        image_rows;
  logic [10:0]       row_bytes;
  logic              direction;

  logic [BYTE_W-1:0] xor_key;
  logic [BYTE_W-1:0] even_key;
  logic [BYTE_W-1:0] odd_key;
  logic [HW-1:0]     permuted;
  logic [HW-1:0]     p_red;
  logic [HW-1:0]     row;
  logic [WW-1:0]     col;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     clr_addr;
  logic              op_load;
  logic [BYTE_W-1:0] byte_r;
  logic              restart_ret;

  logic [HW-1:0]     h;
  logic [WW-1:0]     w;
  logic              accept;
  logic              out_of_image;
  logic              row_wrap;
  logic              slot_free;
  logic [HW-1:0]     sel_row;
  logic [AW-1:0]     addr;

  logic              rem_start;
  logic [DW-1:0]     rem_dividend;
  logic              rem_done;
  logic [HW-1:0]     rem_result;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_rdata;
  logic [BYTE_W-1:0] load_val;
  logic [BYTE_W-1:0] read_val;

  // Effective geometry: zero counts as one, oversize clamps to the maximum.
  always_comb begin
    if (image_rows == '0) begin
      h = HW'(1);
    end else if (32'(image_rows) > 32'(MAX_ROWS)) begin
      h = HW'(MAX_ROWS);
    end else begin
      h = HW'(image_rows);
    end
    if (row_bytes == '0) begin
      w = WW'(1);
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      w = WW'(MAX_ROW_BYTES);
    end else begin
      w = WW'(row_bytes);
    end
  end

  assign accept       = in_valid && in_ready;
  assign out_of_image = (row >= h) || (col >= w);
  assign row_wrap     = (col + WW'(1)) >= w;
  assign slot_free    = !out_valid || out_ready;

  // The permuted row addresses the store on encrypt loads and decrypt reads.
  assign sel_row = (op_load == direction) ? p_red : row;
  assign addr    = AW'(prod + PW'(col));

  assign load_val = !direction ? byte_r
                  : (col[0] ? byte_r - odd_key : even_key - byte_r);
  assign read_val = direction ? mem_rdata
                  : (col[0] ? odd_key + mem_rdata : even_key - mem_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= 9'd1;
      row_bytes  <= 11'd4;
      direction  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS: image_rows <= cfg_data[8:0];
        REG_ROW_BYTES:  row_bytes  <= cfg_data;
        REG_DIRECTION:  direction  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    rem_start    = 1'b0;
    rem_dividend = DW'(permuted);
    mem_we       = 1'b0;
    mem_waddr    = addr;
    mem_wdata    = load_val;
    mem_re       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (operation)
            OP_NAME: begin
              if (first_of_name) begin
                state_next = S_CLEAR;
              end
            end
            OP_LOAD: begin
              case (phase) inside
                PH_NAME, PH_READ: state_next = S_RESTART;
                PH_LOAD:          state_next = S_CHECK;
                default:          state_next = S_IDLE;
              endcase
            end
            OP_READ: begin
              state_next = (phase != PH_READ) ? S_RESTART : S_CHECK;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RESTART: begin
        rem_start    = 1'b1;
        rem_dividend = DW'(xor_key) + DW'(ROW_STEP);
        state_next   = S_RESTART_W;
      end
      S_RESTART_W: begin
        if (rem_done) begin
          state_next = restart_ret ? S_IDLE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_of_image) begin
          state_next = op_load ? S_IDLE : S_RESTART;
        end else begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        rem_start  = 1'b1;
        state_next = S_REDUCE_W;
      end
      S_REDUCE_W: begin
        if (rem_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ACCESS;
      end
      S_ACCESS: begin
        mem_we     = op_load;
        mem_re     = !op_load;
        state_next = op_load ? S_ADV : S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        state_next = row_wrap ? S_STEP : S_IDLE;
      end
      S_STEP: begin
        rem_start    = 1'b1;
        rem_dividend = DW'(p_red) + DW'(ROW_STEP);
        state_next   = S_STEP_W;
      end
      S_STEP_W: begin
        if (rem_done) begin
          // A finished readout starts over at the first row.
          state_next = ((row >= h) && !op_load) ? S_RESTART : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NAME;
      xor_key     <= '0;
      even_key    <= EVEN_KEY_INIT;
      odd_key     <= '0;
      permuted    <= '0;
      row         <= '0;
      col         <= '0;
      clr_addr    <= '0;
      op_load     <= 1'b0;
      restart_ret <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            byte_r      <= byte_in;
            op_load     <= (operation == OP_LOAD);
            restart_ret <= 1'b0;
            case (operation)
              OP_NAME: begin
                phase <= PH_NAME;
                if (first_of_name) begin
                  xor_key  <= byte_in;
                  even_key <= EVEN_KEY_INIT + byte_in;
                  odd_key  <= '0 - byte_in;
                  clr_addr <= '0;
                end else begin
                  xor_key  <= xor_key ^ byte_in;
                  even_key <= even_key + byte_in;
                  odd_key  <= odd_key - byte_in;
                end
              end
              OP_LOAD: begin
                if (phase == PH_NAME || phase == PH_READ) begin
                  phase <= PH_LOAD;
                end
              end
              OP_READ: begin
                phase <= PH_READ;
              end
              default: ;
            endcase
          end
        end
        S_RESTART_W: begin
          if (rem_done) begin
            permuted <= rem_result;
            row      <= '0;
            col      <= '0;
          end
        end
        S_CHECK: begin
          if (out_of_image && op_load) begin
            phase <= PH_FULL;
          end
        end
        S_REDUCE_W: begin
          if (rem_done) begin
            p_red <= rem_result;
          end
        end
        S_MUL: begin
          prod <= PW'(sel_row) * PW'(w);
        end
        S_ADV: begin
          if (row_wrap) begin
            col <= '0;
            row <= row + HW'(1);
          end else begin
            col <= col + WW'(1);
          end
        end
        S_STEP_W: begin
          if (rem_done) begin
            permuted <= rem_result;
            if (row >= h) begin
              if (op_load) begin
                phase <= PH_FULL;
              end else begin
                restart_ret <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && slot_free) begin
      out_valid     <= 1'b1;
      byte_out      <= read_val;
      last_of_image <= (row == h - HW'(1)) && (col == w - WW'(1));
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  irsc_rem #(
    .DW (DW),
    .HW (HW)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (h),
    .done      (rem_done),
    .remainder (rem_result)
  );

  irsc_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  a_access_in_image: assert property (@(posedge clk) disable iff (rst)
    state == S_ACCESS |-> (row < h) && (col < w))
    else $error("store access outside the image");

  a_row_reduced: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> p_red < h)
    else $error("permuted row not reduced");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && out_valid && !out_ready |=> state == S_OUT && $stable(byte_out))
    else $error("pending result overwritten");

endmodule

[rtl/irsc_rem.sv]
// Iterative restoring remainder unit, one compare and subtract per cycle.
`timescale 1ns / 1ps

module irsc_rem #(
  parameter int DW = 9,
  parameter int HW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [HW-1:0] divisor,
  output logic          done,
  output logic [HW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [DW-1:0] dvd;
  logic [HW-1:0] div_r;
  logic [HW:0]   trial;
  logic [HW:0]   diff;
  logic          fits;

  assign trial = {remainder, dvd[DW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        div_r <= divisor;
        // A dividend already below the divisor is its own remainder.
        if (dividend < DW'(divisor)) begin
          remainder <= HW'(dividend);
          done      <= 1'b1;
          busy      <= 1'b0;
        end else begin
          remainder <= '0;
          dvd       <= dividend;
          count     <= CW'(DW);
          busy      <= 1'b1;
        end
      end else if (busy) begin
        remainder <= fits ? diff[HW-1:0] : trial[HW-1:0];
        dvd       <= dvd << 1;
        count     <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit started while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> remainder < div_r)
    else $error("remainder not below divisor");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

[rtl/irsc_store.sv]
// Frame store with one write port, one read port and registered read data.
`timescale 1ns / 1ps

module irsc_store
  import irsc_pkg::*;
#(
  parameter int  DEPTH = 262144,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the image row scramble cipher.
`timescale 1ns / 1ps

module tb_top
  import irsc_pkg::*;
;

  localparam int MAX_ROWS       = 256;
  localparam int MAX_ROW_BYTES  = 1024;
  localparam int STORE_DEPTH    = MAX_ROWS * MAX_ROW_BYTES;
  localparam int TOTAL_ITEMS    = 900;
  localparam int TAIL_CYCLES    = 80;
  localparam int LONG_HOLD      = 300;
  localparam int STALL_LIMIT    = 1000000;
  localparam int FIRST_MARK_SEG = 6;
  localparam int MAX_PRINTED    = 40;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } out_byte_t;

  class cipher_scoreboard;
    int unsigned       rows_cfg;
    int unsigned       bytes_cfg;
    bit                dir_cfg;
    logic [BYTE_W-1:0] xor_key;
    logic [BYTE_W-1:0] even_key;
    logic [BYTE_W-1:0] odd_key;
    int                perm_row;
    int                row_cnt;
    int                col_cnt;
    phase_t            phase;
    logic [BYTE_W-1:0] frame [STORE_DEPTH];
    out_byte_t         pending_bytes [$];
    int                mismatches;
    int                checked;
    int                items_by_op [4];

    function new();
      rows_cfg   = 1;
      bytes_cfg  = 4;
      dir_cfg    = 1'b0;
      xor_key    = '0;
      even_key   = EVEN_KEY_INIT;
      odd_key    = '0;
      perm_row   = 0;
      row_cnt    = 0;
      col_cnt    = 0;
      phase      = PH_NAME;
      mismatches = 0;
      checked    = 0;
      foreach (items_by_op[i]) items_by_op[i] = 0;
      foreach (frame[i]) frame[i] = '0;
    endfunction

    function int rows_in_use();
      if (rows_cfg == 0) return 1;
      if (rows_cfg > MAX_ROWS) return MAX_ROWS;
      return rows_cfg;
    endfunction

    function int bytes_in_use();
      if (bytes_cfg == 0) return 1;
      if (bytes_cfg > MAX_ROW_BYTES) return MAX_ROW_BYTES;
      return bytes_cfg;
    endfunction

    function void restart_scan(int h);
      row_cnt  = 0;
      col_cnt  = 0;
      perm_row = (int'(xor_key) + ROW_STEP) % h;
    endfunction

    function void step_scan(int h, int w);
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        perm_row = (perm_row % h + ROW_STEP) % h;
      end
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_IMAGE_ROWS: rows_cfg = 32'(data[8:0]);
        REG_ROW_BYTES:  bytes_cfg = 32'(data);
        REG_DIRECTION:  dir_cfg = data[0];
        default: ;
      endcase
    endfunction

    // Advances the cipher state by one accepted item; a read item leaves the
    // byte it must produce at the back of the queue.
    function void take_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b, logic first);
      int                h;
      int                w;
      logic [BYTE_W-1:0] s;
      logic [BYTE_W-1:0] v;
      out_byte_t         e;
      h = rows_in_use();
      w = bytes_in_use();
      items_by_op[op]++;
      if (op == OP_NAME) begin
        if (first) begin
          xor_key  = '0;
          even_key = EVEN_KEY_INIT;
          odd_key  = '0;
          foreach (frame[i]) frame[i] = '0;
        end
        xor_key  = xor_key ^ b;
        even_key = even_key + b;
        odd_key  = odd_key - b;
        phase    = PH_NAME;
      end else if (op == OP_LOAD) begin
        if (phase == PH_NAME || phase == PH_READ) begin
          restart_scan(h);
          phase = PH_LOAD;
        end
        if (phase == PH_LOAD) begin
          if (row_cnt >= h || col_cnt >= w) begin
            phase = PH_FULL;
          end else begin
            if (!dir_cfg) begin
              frame[row_cnt * w + col_cnt] = b;
            end else begin
              v = (col_cnt % 2 == 0) ? even_key - b : b - odd_key;
              frame[(perm_row % h) * w + col_cnt] = v;
            end
            step_scan(h, w);
            if (row_cnt >= h) phase = PH_FULL;
          end
        end
      end else if (op == OP_READ) begin
        if (phase != PH_READ) begin
          restart_scan(h);
          phase = PH_READ;
        end
        if (row_cnt >= h || col_cnt >= w) restart_scan(h);
        if (!dir_cfg) begin
          s = frame[(perm_row % h) * w + col_cnt];
          v = (col_cnt % 2 == 0) ? even_key - s : odd_key + s;
        end else begin
          v = frame[row_cnt * w + col_cnt];
        end
        e.value = v;
        e.last  = (row_cnt == h - 1) && (col_cnt == w - 1);
        pending_bytes.push_back(e);
        step_scan(h, w);
        if (row_cnt >= h) restart_scan(h);
      end
    endfunction

    task report(string msg);
      // Only the first few are printed so a broken build cannot flood the log.
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_byte(logic [BYTE_W-1:0] value, logic last);
      out_byte_t e;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing expected", value));
      end else begin
        e = pending_bytes.pop_front();
        checked++;
        if (value !== e.value)
          report($sformatf("byte_out %02h, expected %02h", value, e.value));
        if (last !== e.last)
          report($sformatf("last_of_image %b, expected %b", last, e.last));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      operation = '0;
  logic [BYTE_W-1:0]    byte_in = '0;
  logic                 first_of_name = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    byte_out;
  logic                 last_of_image;

  cipher_scoreboard sb = new();

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int sent_items = 0;
  int stall_cycles = 0;
  int segments = 0;

  image_row_scramble_cipher #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .byte_in       (byte_in),
    .first_of_name (first_of_name),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_out      (byte_out),
    .last_of_image (last_of_image)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both channels are sampled at the edge, before any of this edge's updates.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.take_item(operation, byte_in, first_of_name);
    if (!rst && out_valid && out_ready)
      sb.check_byte(byte_out, last_of_image);
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : receiver
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        // Long hold-off so the output register fills and the input backs up.
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Valid is left high after an accepted item; the next call either keeps it
  // high with a new payload or lowers it for a gap, in the same time step.
  task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b, logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    byte_in       <= b;
    first_of_name <= first;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (op != OP_UNUSED) sent_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(int rows, int row_len, bit dir);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_ROWS;
    cfg_data  <= CFG_W'(rows);
    sb.note_config(REG_IMAGE_ROWS, CFG_W'(rows));
    @(posedge clk);
    cfg_index <= REG_ROW_BYTES;
    cfg_data  <= CFG_W'(row_len);
    sb.note_config(REG_ROW_BYTES, CFG_W'(row_len));
    @(posedge clk);
    cfg_index <= REG_DIRECTION;
    cfg_data  <= CFG_W'(dir);
    sb.note_config(REG_DIRECTION, CFG_W'(dir));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_segment(int seg);
    int r;
    int rows;
    int row_len;
    int kind;
    int area;
    int n;
    r = $urandom_range(0, 99);
    if (r < 75) rows = $urandom_range(1, 6);
    else if (r < 85) rows = $urandom_range(7, 24);
    else if (r < 92) rows = 0;
    else rows = $urandom_range(0, 511);
    r = $urandom_range(0, 99);
    if (r < 75) row_len = $urandom_range(1, 6);
    else if (r < 85) row_len = $urandom_range(7, 40);
    else if (r < 92) row_len = 0;
    else row_len = $urandom_range(0, 2047);
    // The first segments pin the geometry to its extremes.
    if (seg == 0) begin
      rows = 0;
      row_len = 0;
    end else if (seg == 1) begin
      rows = 511;
      row_len = 2047;
    end else if (seg == 2) begin
      rows = MAX_ROWS;
      row_len = MAX_ROW_BYTES;
    end
    idle_on = ($urandom_range(0, 3) != 0);
    write_regs(rows, row_len, 1'($urandom_range(0, 1)));
    if (seg == 3) hold_request = 1'b1;
    area = sb.rows_in_use() * sb.bytes_in_use();
    kind = (seg <= 3 || seg == FIRST_MARK_SEG) ? 0 : $urandom_range(0, 99);
    if (kind < 55) begin
      // A whole job: key, load up to 48 image bytes plus up to two spare, read back.
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_item(OP_NAME, BYTE_W'($urandom_range(0, 255)),
                  (i == 0) && (seg == FIRST_MARK_SEG));
      n = (area > 48 ? 48 : area) + $urandom_range(0, 2);
      for (int i = 0; i < n; i++)
        send_item(OP_LOAD, BYTE_W'($urandom_range(0, 255)), 1'b0);
      if (seg == 3) n = 60;
      else n = $urandom_range(1, (2 * area + 1 > 48) ? 48 : 2 * area + 1);
      for (int i = 0; i < n; i++)
        send_item(OP_READ, BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 75) begin
      // Carry on the previous job under the new geometry.
      n = $urandom_range(2, 16);
      for (int i = 0; i < n; i++)
        send_item($urandom_range(0, 1) ? OP_LOAD : OP_READ,
                  BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 85) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++)
        send_item(OP_READ, BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else begin
      n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++)
        send_item(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)), 1'b0);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int seg;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_regs(3, 2, 1'b0);

    // Decrypt job on a 3 x 2 image: first-marked name, extreme bytes, one
    // spare load byte, the unused operation code and a read that wraps.
    send_item(OP_NAME, 8'hFF, 1'b1);
    send_item(OP_NAME, 8'h00, 1'b0);
    send_item(OP_NAME, 8'h81, 1'b0);
    send_item(OP_LOAD, 8'h00, 1'b0);
    send_item(OP_LOAD, 8'hFF, 1'b0);
    send_item(OP_LOAD, 8'h01, 1'b0);
    send_item(OP_LOAD, 8'h80, 1'b0);
    send_item(OP_LOAD, 8'h7F, 1'b0);
    send_item(OP_LOAD, 8'h55, 1'b0);
    send_item(OP_LOAD, 8'hAA, 1'b0);
    send_item(OP_UNUSED, 8'hC3, 1'b1);
    for (int i = 0; i < 7; i++) send_item(OP_READ, 8'h00, 1'b0);
    // A name byte without the first mark rekeys but keeps the stored image.
    send_item(OP_NAME, 8'h5A, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_READ, 8'hFF, 1'b0);
    wait_idle();
    write_regs(3, 2, 1'b1);
    send_item(OP_LOAD, 8'h3C, 1'b0);
    send_item(OP_LOAD, 8'hC3, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    wait_idle();

    seg = 0;
    while (sent_items < TOTAL_ITEMS) begin
      run_segment(seg);
      seg++;
    end
    segments = seg;

    if (sb.pending_bytes.size() != 0)
      sb.report($sformatf("%0d result bytes never arrived", sb.pending_bytes.size()));
    $display("run covered %0d name, %0d load, %0d read and %0d unused-code items in %0d segments",
             sb.items_by_op[OP_NAME], sb.items_by_op[OP_LOAD], sb.items_by_op[OP_READ],
             sb.items_by_op[OP_UNUSED], segments);
    $display("%0d result bytes checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/irsc_pkg.sv
rtl/irsc_rem.sv
rtl/irsc_store.sv
rtl/image_row_scramble_cipher.sv
tb/sv/tb_top.sv
